// ===== rtl/dps_pkg.sv =====
// Package for the delimiter part splitter.
// Holds payload widths, register indexes and saturation limits shared by all files.
// No dependencies.
package dps_pkg;

  localparam int unsigned DATA_W       = 8;
  localparam int unsigned SEP_BYTES_W  = 64;
  localparam int unsigned SEP_LEN_W    = 4;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned PART_OFF_W   = 32;
  localparam int unsigned PART_LEN_W   = 32;
  localparam int unsigned SINCE_W      = 4;

  localparam logic [SINCE_W-1:0]    SINCE_MAX  = '1;
  localparam logic [PART_LEN_W-1:0] LENGTH_MAX = '1;

  localparam logic [SEP_BYTES_W-1:0] SEP_BYTES_RESET = 64'h0000_0000_0000_0A0D;
  localparam logic [SEP_LEN_W-1:0]   SEP_LEN_RESET   = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEPARATOR_BYTES  = 2'd0,
    REG_SEPARATOR_LENGTH = 2'd1
  } cfg_reg_e;

endpackage

// ===== rtl/dps_if.sv =====
// Valid/ready channel interfaces of the delimiter part splitter.
// One interface for incoming bytes and one for completed parts; uses dps_pkg.
interface dps_byte_if;
  logic                        valid;
  logic                        ready;
  logic [dps_pkg::DATA_W-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface dps_part_if;
  logic                            valid;
  logic                            ready;
  logic [dps_pkg::PART_OFF_W-1:0]  part_offset;
  logic [dps_pkg::PART_LEN_W-1:0]  part_length;

  modport source (output valid, output part_offset, output part_length, input ready);
  modport sink   (input valid, input part_offset, input part_length, output ready);
endinterface

// ===== rtl/dps_match.sv =====
// Separator compare for the delimiter part splitter.
// Compares the byte window against every possible separator length in parallel; uses dps_pkg.
module dps_match #(
  parameter int unsigned MAX_SEPARATOR_BYTES = 8
) (
  input  logic [8*MAX_SEPARATOR_BYTES-1:0]  window_i,
  input  logic [dps_pkg::SEP_BYTES_W-1:0]   sep_bytes_i,
  input  logic [dps_pkg::SEP_LEN_W-1:0]     sep_len_i,
  input  logic [dps_pkg::SINCE_W-1:0]       since_i,
  output logic                              match_o
);
  import dps_pkg::*;

  logic [MAX_SEPARATOR_BYTES-1:0] len_hit;
  logic [SEP_LEN_W-1:0]           eff_len;

  // Newest byte sits in bits 7:0 of the window, so separator byte i of a
  // separator of length l lines up with window byte l-1-i.
  for (genvar l = 1; l <= MAX_SEPARATOR_BYTES; l++) begin : g_len
    logic [l-1:0] byte_eq;
    for (genvar i = 0; i < l; i++) begin : g_byte
      assign byte_eq[i] = (sep_bytes_i[8*i +: 8] == window_i[8*(l-1-i) +: 8]);
    end
    assign len_hit[l-1] = &byte_eq;
  end

  // A length of zero acts as one; anything above the window acts as the window.
  always_comb begin
    if (sep_len_i == '0) begin
      eff_len = SEP_LEN_W'(1);
    end else if (sep_len_i > SEP_LEN_W'(MAX_SEPARATOR_BYTES)) begin
      eff_len = SEP_LEN_W'(MAX_SEPARATOR_BYTES);
    end else begin
      eff_len = sep_len_i;
    end
  end

  always_comb begin
    match_o = 1'b0;
    for (int unsigned l = 1; l <= MAX_SEPARATOR_BYTES; l++) begin
      if (eff_len == SEP_LEN_W'(l)) begin
        match_o = len_hit[l-1];
      end
    end
    if (SINCE_W'(eff_len) > since_i) begin
      match_o = 1'b0;
    end
  end

endmodule

// ===== rtl/delimiter_part_splitter.sv =====
// Top level of the delimiter part splitter.
// Depends on dps_pkg, the channel interfaces in dps_if.sv and dps_match.
//
// Usage:
// Bytes of a stream enter on the data_i channel, one byte per item. The block
// splits the stream into parts that each end with a separator of 1 to 8 bytes,
// set by two configuration registers (separator bytes, first byte in bits 7:0,
// and separator length). For every completed separator one item leaves on the
// part_o channel: the stream offset of the part's first byte and the part's
// length, separator included. Matches never overlap: every separator byte must
// have arrived after the previous boundary. Offsets wrap, lengths saturate.
// An accepted byte is held in the input register; its result, if any, is
// registered in the output register, from which the receiver takes it.
// Throughput: one byte per cycle while no byte that completes a separator waits
// for the output register, set by the single compare stage between the input
// register and the output register.
// Reset clears the stream position, the open part and the byte history, and
// loads the separator CR LF of length two.
// When the receiver stalls, the held result waits in the output register and
// bytes without a result keep flowing; only a byte that completes a separator
// waits until the output register is free, which then stalls data_i.
// The user must write configuration only while the block holds no item; the block does not enforce it.
module delimiter_part_splitter #(
  parameter int unsigned MAX_SEPARATOR_BYTES = 8,
  parameter int unsigned OFFSET_BITS         = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dps_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  dps_byte_if.sink                        data_i,
  dps_part_if.source                      part_o
);
  import dps_pkg::*;

  localparam int unsigned WIN_W = 8 * MAX_SEPARATOR_BYTES;

  // Configuration registers.
  logic [SEP_BYTES_W-1:0] sep_bytes_q;
  logic [SEP_LEN_W-1:0]   sep_len_q;

  // Stream state.
  logic [WIN_W-1:0]       recent_q, recent_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [SINCE_W-1:0]     since_q, since_d, since_next;
  logic [PART_LEN_W-1:0]  count_q, count_d, count_next;

  // Input register.
  logic                   in_valid_q;
  logic [DATA_W-1:0]      in_byte_q;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  logic [PART_OFF_W-1:0]  out_offset_q;
  logic [PART_LEN_W-1:0]  out_length_q;

  logic                          match;
  logic                          advance;
  logic                          emit;
  logic [OFFSET_BITS+PART_OFF_W-1:0] start_wide;

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_bytes_q <= SEP_BYTES_RESET;
      sep_len_q   <= SEP_LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SEPARATOR_BYTES:  sep_bytes_q <= cfg_wdata_i[SEP_BYTES_W-1:0];
        REG_SEPARATOR_LENGTH: sep_len_q   <= cfg_wdata_i[SEP_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Window as it will be once the held byte is shifted in.
  assign recent_d   = WIN_W'({recent_q, in_byte_q});
  assign since_next = (since_q == SINCE_MAX) ? since_q : since_q + SINCE_W'(1);
  assign count_next = (count_q == LENGTH_MAX) ? count_q : count_q + PART_LEN_W'(1);
  assign pos_d      = pos_q + OFFSET_BITS'(1);

  dps_match #(
    .MAX_SEPARATOR_BYTES(MAX_SEPARATOR_BYTES)
  ) u_match (
    .window_i    (recent_d),
    .sep_bytes_i (sep_bytes_q),
    .sep_len_i   (sep_len_q),
    .since_i     (since_next),
    .match_o     (match)
  );

  // A byte without a result always moves on; a byte with one needs a free
  // output register, or one that is being emptied in this cycle.
  assign advance      = in_valid_q && (!match || !out_valid_q || part_o.ready);
  assign emit         = advance && match;
  assign data_i.ready = !in_valid_q || advance;

  // The part offset is the low bits of the start position, zero-extended
  // when positions are narrower than the output field.
  assign start_wide = {{PART_OFF_W{1'b0}}, start_q};

  always_comb begin
    start_d = start_q;
    since_d = since_next;
    count_d = count_next;
    if (match) begin
      start_d = pos_d;
      since_d = '0;
      count_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !part_o.ready;
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      recent_q    <= '0;
      pos_q       <= '0;
      start_q     <= '0;
      since_q     <= '0;
      count_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (data_i.ready) begin
        in_valid_q <= data_i.valid;
      end
      if (advance) begin
        recent_q <= recent_d;
        pos_q    <= pos_d;
        start_q  <= start_d;
        since_q  <= since_d;
        count_q  <= count_d;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (data_i.valid && data_i.ready) begin
      in_byte_q <= data_i.data_byte;
    end
    if (emit) begin
      out_offset_q <= start_wide[PART_OFF_W-1:0];
      out_length_q <= count_next;
    end
  end

  assign part_o.valid       = out_valid_q;
  assign part_o.part_offset = out_offset_q;
  assign part_o.part_length = out_length_q;

`ifndef SYNTHESIS
  // Every emitted part holds at least its final separator byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (part_o.valid && part_o.part_length != '0))
    else $error("part emitted with zero length");

  // A boundary restarts both the overlap guard and the length count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (since_q == '0 && count_q == '0))
    else $error("boundary did not clear the open part");

  // The saturating guard counter and the length counter move together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (since_q != SINCE_MAX) |-> (count_q == PART_LEN_W'(since_q)))
    else $error("byte counters out of step");

  // A held byte is neither lost nor altered while it waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("waiting byte lost");
`endif

endmodule
